FILE: sv/jsu_pkg.sv
// Package for the JSON string unescaper: character codes, result group type
// and the small decode functions used by the decoder.
// No dependencies.
package jsu_pkg;

    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_U      = 8'h75;

    localparam logic [15:0] SURR_HI_MIN = 16'hD800;
    localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
    localparam logic [20:0] PLANE_BASE  = 21'h10000;

    localparam int unsigned MAX_EMIT = 6;
    localparam int unsigned CNT_W    = 3;

    typedef struct packed {
        logic [MAX_EMIT-1:0][7:0] data;
        logic [CNT_W-1:0]         count;
        logic                     last;
    } emit_t;

    typedef struct packed {
        logic [2:0][7:0] data;
        logic [1:0]      count;
    } code_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_of(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'h0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.val = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic logic [7:0] simple_escape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h62:   r = 8'h08;
            8'h66:   r = 8'h0C;
            8'h6E:   r = 8'h0A;
            8'h72:   r = 8'h0D;
            8'h74:   r = 8'h09;
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic code_t put_code(input logic [15:0] cp);
        code_t r;
        r.data = '0;
        if (cp < 16'h0080) begin
            r.data[0] = cp[7:0];
            r.count   = 2'd1;
        end else if (cp < 16'h0800) begin
            r.data[0] = {3'b110, cp[10:6]};
            r.data[1] = {2'b10, cp[5:0]};
            r.count   = 2'd2;
        end else begin
            r.data[0] = {4'b1110, cp[15:12]};
            r.data[1] = {2'b10, cp[11:6]};
            r.data[2] = {2'b10, cp[5:0]};
            r.count   = 2'd3;
        end
        return r;
    endfunction

endpackage

FILE: sv/jsu_decode.sv
// Escape decoder: the decode state registers and the logic that turns one
// registered character into up to six result bytes. Depends on jsu_pkg.
module jsu_decode (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output jsu_pkg::emit_t o_emit
);
    import jsu_pkg::*;

    typedef enum logic [3:0] {
        ST_EMPTY = 4'b0001,
        ST_BS    = 4'b0010,
        ST_U     = 4'b0100,
        ST_HI    = 4'b1000
    } dec_state_t;

    dec_state_t      state_reg, state_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic [2:0][7:0] dig_reg, dig_next;
    logic [15:0]     hi_reg, hi_next;

    function automatic code_t tail_decode(input logic [2:0][7:0] t, input logic [1:0] m);
        code_t      r;
        logic [2:0] i;
        logic [1:0] n;
        r.data = '0;
        i = 3'd0;
        n = 2'd0;
        for (int s = 0; s < 3; s++) begin
            if (i < {1'b0, m}) begin
                if (t[i[1:0]] != CHAR_BSLASH) begin
                    r.data[n] = t[i[1:0]];
                    n = n + 2'd1;
                    i = i + 3'd1;
                end else if (i + 3'd1 == {1'b0, m}) begin
                    r.data[n] = CHAR_BSLASH;
                    n = n + 2'd1;
                    i = 3'd4;
                end else if (t[2'(i + 3'd1)] != CHAR_U) begin
                    r.data[n] = simple_escape(t[2'(i + 3'd1)]);
                    n = n + 2'd1;
                    i = i + 3'd2;
                end else begin
                    i = i + 3'd2;
                end
            end
        end
        r.count = n;
        return r;
    endfunction

    hex_t        hb;
    hex_t [2:0]  hd;
    logic [15:0] code_val;
    logic        code_ok;
    logic        fail;
    logic        pair;
    logic        prefix;
    dec_state_t  eff_state;
    logic [1:0]  eff_d;

    code_t       base_code;
    dec_state_t  base_state;
    logic [2:0]  base_cnt;
    logic        base_store;
    logic        base_hi_load;
    logic [2:0][7:0] tail_chars;
    code_t       hi_code;
    logic [20:0] full;

    always_comb begin
        hb = hex_of(i_byte);
        for (int j = 0; j < 3; j++) begin
            hd[j] = hex_of(dig_reg[j]);
        end
        code_val = {hd[0].val, hd[1].val, hd[2].val, hb.val};
        code_ok  = hd[0].ok && hd[1].ok && hd[2].ok && hb.ok;
        full = PLANE_BASE + {1'b0, hi_reg[9:0], hd[1].val[1:0], hd[2].val, hb.val};
        hi_code = put_code(hi_reg);
        case (cnt_reg)
            3'd0:    fail = (i_byte != CHAR_BSLASH);
            3'd1:    fail = (i_byte != CHAR_U);
            3'd2:    fail = !(hb.ok && hb.val == 4'hD);
            3'd3:    fail = !(hb.ok && hb.val >= 4'hC);
            default: fail = !hb.ok;
        endcase
    end

    always_comb begin
        if (state_reg == ST_HI) begin
            if (cnt_reg == 3'd0) begin
                eff_state = ST_EMPTY;
                eff_d     = 2'd0;
            end else if (cnt_reg == 3'd1) begin
                eff_state = ST_BS;
                eff_d     = 2'd0;
            end else begin
                eff_state = ST_U;
                eff_d     = 2'(cnt_reg - 3'd2);
            end
        end else begin
            eff_state = state_reg;
            eff_d     = cnt_reg[1:0];
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            tail_chars[j] = (2'(j) < eff_d) ? dig_reg[j] : i_byte;
        end
        base_code       = '0;
        base_state      = ST_EMPTY;
        base_cnt        = 3'd0;
        base_store      = 1'b0;
        base_hi_load    = 1'b0;
        unique case (eff_state)
            ST_EMPTY: begin
                if (i_byte != CHAR_BSLASH) begin
                    base_code.data[0] = i_byte;
                    base_code.count   = 2'd1;
                end else if (i_last) begin
                    base_code.data[0] = CHAR_BSLASH;
                    base_code.count   = 2'd1;
                end else begin
                    base_state = ST_BS;
                end
            end
            ST_BS: begin
                if (i_byte != CHAR_U) begin
                    base_code.data[0] = simple_escape(i_byte);
                    base_code.count   = 2'd1;
                end else if (!i_last) begin
                    base_state = ST_U;
                end
            end
            ST_U: begin
                if (eff_d != 2'd3) begin
                    if (i_last) begin
                        base_code = tail_decode(tail_chars, 2'(eff_d + 2'd1));
                    end else begin
                        base_store = 1'b1;
                        base_state = ST_U;
                        base_cnt   = {1'b0, eff_d} + 3'd1;
                    end
                end else if (code_ok) begin
                    if (code_val >= SURR_HI_MIN && code_val <= SURR_HI_MAX && !i_last) begin
                        base_hi_load = 1'b1;
                        base_state   = ST_HI;
                    end else begin
                        base_code = put_code(code_val);
                    end
                end
            end
            default: begin
                base_state = ST_EMPTY;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        dig_next     = dig_reg;
        hi_next      = hi_reg;
        o_emit       = '0;
        o_emit.last  = i_last;
        pair         = (state_reg == ST_HI) && (cnt_reg == 3'd5) && !fail;
        prefix       = (state_reg == ST_HI) && !pair && (fail || i_last);
        if (pair) begin
            state_next     = ST_EMPTY;
            cnt_next       = 3'd0;
            o_emit.data[0] = {5'b11110, full[20:18]};
            o_emit.data[1] = {2'b10, full[17:12]};
            o_emit.data[2] = {2'b10, full[11:6]};
            o_emit.data[3] = {2'b10, full[5:0]};
            o_emit.count   = 3'd4;
        end else if (state_reg == ST_HI && !prefix) begin
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg >= 3'd2) begin
                dig_next[2'(cnt_reg - 3'd2)] = i_byte;
            end
        end else begin
            state_next = base_state;
            cnt_next   = base_cnt;
            if (base_store) begin
                dig_next[eff_d] = i_byte;
            end
            if (base_hi_load) begin
                hi_next = code_val;
            end
            if (prefix) begin
                o_emit.data[2:0] = hi_code.data;
                o_emit.data[5:3] = base_code.data;
                o_emit.count     = 3'd3 + {1'b0, base_code.count};
            end else begin
                o_emit.data[2:0] = base_code.data;
                o_emit.count     = {1'b0, base_code.count};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_EMPTY;
            cnt_reg   <= 3'd0;
        end else if (i_valid) begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (i_valid) begin
            dig_reg <= dig_next;
            hi_reg  <= hi_next;
        end
    end

endmodule

FILE: sv/jsu_outbuf.sv
// Result buffer: holds the bytes decoded from one character and sends them
// out on the master stream, one per cycle while m_tready is high. Depends on jsu_pkg.
module jsu_outbuf (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           load,
    input  jsu_pkg::emit_t emit_i,
    output logic           free,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,   // out_byte
    output logic           m_tlast,
    output logic [0:0]     m_tuser    // string_end
);
    import jsu_pkg::*;

    logic [MAX_EMIT-1:0][7:0] data_reg, data_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     end_reg, end_next;
    logic                     pop;

    assign pop      = m_tvalid && m_tready;
    assign free     = (cnt_reg == '0) || (cnt_reg == CNT_W'(1) && m_tready);
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = data_reg[0];
    assign m_tlast  = (cnt_reg == CNT_W'(1));
    assign m_tuser  = end_reg;

    always_comb begin
        data_next = data_reg;
        cnt_next  = cnt_reg;
        end_next  = end_reg;
        if (load) begin
            data_next = emit_i.data;
            cnt_next  = emit_i.count;
            end_next  = emit_i.last;
        end else if (pop) begin
            data_next = data_reg >> 8;
            cnt_next  = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        end_reg  <= end_next;
    end

endmodule

FILE: sv/json_string_unescape_to_utf8.sv
// Top level of the JSON string unescaper: input register, escape decoder
// and result buffer. Depends on jsu_pkg, jsu_decode and jsu_outbuf.
//
// The slave stream carries one raw character of an escaped JSON string body
// per request in s_tdata, with s_tlast high on the final character. The
// master stream returns the decoded bytes (UTF-8 for unicode escapes), one
// per request; m_tlast marks the final byte caused by one input character
// and m_tuser is high on bytes caused by the final character of a string.
// A character is taken into an input register, decoded from there and
// loaded into the result buffer once that buffer is free; its bytes then
// appear on the master side from the result buffer. A character that
// yields several bytes holds the result buffer until its last byte is
// taken, and the next character is loaded as that last byte leaves.
// When the receiver stalls, the result buffer holds and one further
// character waits in the input register. Reset empties both and returns
// the decoder to plain text.
module json_string_unescape_to_utf8 (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast,
    output logic [0:0] m_tuser    // string_end
);
    import jsu_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       free;
    logic       advance;
    logic       accept;
    emit_t      emit;

    assign advance  = in_valid_reg && free;
    assign s_tready = !in_valid_reg || free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    jsu_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .i_valid (advance),
        .i_byte  (in_byte_reg),
        .i_last  (in_last_reg),
        .o_emit  (emit)
    );

    jsu_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .emit_i   (emit),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
